FILE: rtl/core/rle_pkg.sv
`timescale 1ns / 1ps

package rle_pkg;

  // Field widths of the encoded and decoded streams
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int WORD_W  = 64;
  localparam int BCNT_W  = 4;
  localparam int LANES   = WORD_W / CODE_W;

  // Header byte layout
  localparam int                 REPEAT_BIT = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'h7F;

  // Most words one repeat run may produce
  localparam int MAX_WORDS = 16;

  // Record phase codes
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_VALUE   = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic emit;    // push next word of a repeat run
  } rle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic run_start;   // current phase expects a repeat value with nonzero count
    logic last_word;   // run has one word left
  } rle_sts_t;

endpackage

FILE: rtl/core/rle_if.sv
`timescale 1ns / 1ps

// Encoded byte channel
interface rle_in_if;
  logic                      valid;
  logic                      ready;
  logic [rle_pkg::CODE_W-1:0] code_byte;
  logic                      stream_end;

  modport source (output valid, output code_byte, output stream_end, input ready);
  modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

// Decoded word channel
interface rle_out_if;
  logic                        valid;
  logic                        ready;
  logic [rle_pkg::WORD_W-1:0]  out_word;
  logic [rle_pkg::BCNT_W-1:0]  byte_count;
  logic                        last_of_item;
  logic                        stream_done;
  logic                        truncated;

  modport source (output valid, output out_word, output byte_count, output last_of_item,
                  output stream_done, output truncated, input ready);
  modport sink   (input valid, input out_word, input byte_count, input last_of_item,
                  input stream_done, input truncated, output ready);
endinterface

FILE: rtl/core/rle_ctrl.sv
`timescale 1ns / 1ps

module rle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rle_pkg::rle_sts_t sts_i,
  output rle_pkg::rle_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_q, state_d;

  // Take items only while idle and the output slot is free
  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.emit   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i && sts_i.out_free;
        if (cmd_o.accept && sts_i.run_start) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free && sts_i.last_word) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/rle_dp.sv
`timescale 1ns / 1ps

module rle_dp #(
  parameter int WORD_BYTES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rle_pkg::rle_cmd_t            cmd_i,
  output rle_pkg::rle_sts_t            sts_o,
  input  logic [rle_pkg::CODE_W-1:0]   code_byte_i,
  input  logic                         stream_end_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [rle_pkg::WORD_W-1:0]   out_word_o,
  output logic [rle_pkg::BCNT_W-1:0]   byte_count_o,
  output logic                         last_of_item_o,
  output logic                         stream_done_o,
  output logic                         truncated_o
);

  localparam int WB_EFF  = (WORD_BYTES < 1) ? 1 : ((WORD_BYTES > 8) ? 8 : WORD_BYTES);
  localparam int CAP_RAW = rle_pkg::MAX_WORDS * WB_EFF;
  localparam int CAP_EFF = (CAP_RAW > 127) ? 127 : CAP_RAW;
  localparam logic [rle_pkg::COUNT_W-1:0] WB_C  = rle_pkg::COUNT_W'(WB_EFF);
  localparam logic [rle_pkg::COUNT_W-1:0] CAP_C = rle_pkg::COUNT_W'(CAP_EFF);
  localparam logic [rle_pkg::BCNT_W-1:0]  WB_N  = rle_pkg::BCNT_W'(WB_EFF);

  // Record state
  logic [1:0]                     phase_q, phase_d;
  logic [rle_pkg::COUNT_W-1:0]    rem_q, rem_d;
  // Repeat run in progress
  logic [rle_pkg::COUNT_W-1:0]    left_q, left_d;
  logic [rle_pkg::CODE_W-1:0]     val_q, val_d;
  logic                           end_q, end_d;
  // Output register
  logic                           ovalid_q, ovalid_d;
  logic [rle_pkg::WORD_W-1:0]     oword_q, oword_d;
  logic [rle_pkg::BCNT_W-1:0]     ocnt_q, ocnt_d;
  logic                           olast_q, olast_d;
  logic                           odone_q, odone_d;
  logic                           otrunc_q, otrunc_d;

  logic [rle_pkg::COUNT_W-1:0]    rem_dec;
  logic [rle_pkg::COUNT_W-1:0]    hdr_cnt;
  logic [1:0]                     hdr_phase;
  logic [rle_pkg::BCNT_W-1:0]     run_n;
  logic [rle_pkg::WORD_W-1:0]     run_word;

  assign rem_dec   = rem_q - 1'b1;
  assign hdr_cnt   = code_byte_i[rle_pkg::COUNT_W-1:0] & rle_pkg::COUNT_MAX;
  assign hdr_phase = code_byte_i[rle_pkg::REPEAT_BIT] ? rle_pkg::PH_VALUE :
                     ((hdr_cnt != '0) ? rle_pkg::PH_LITERAL : rle_pkg::PH_HEADER);

  // Next repeat word: min(left, word size) copies of the value byte
  assign run_n = (left_q < WB_C) ? left_q[rle_pkg::BCNT_W-1:0] : WB_N;
  always_comb begin
    for (int i = 0; i < rle_pkg::LANES; i++) begin
      run_word[i*rle_pkg::CODE_W +: rle_pkg::CODE_W] =
        (rle_pkg::BCNT_W'(i) < run_n) ? val_q : '0;
    end
  end

  // Status for the controller
  assign sts_o.out_free  = !ovalid_q || out_ready_i;
  assign sts_o.run_start = (phase_q == rle_pkg::PH_VALUE) && (rem_q != '0);
  assign sts_o.last_word = (left_q <= WB_C);

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    left_d   = left_q;
    val_d    = val_q;
    end_d    = end_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oword_d  = oword_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    odone_d  = odone_q;
    otrunc_d = otrunc_q;

    if (cmd_i.accept) begin
      unique case (phase_q)
        rle_pkg::PH_VALUE: begin
          // Latch the value; the run itself leaves over the next cycles
          val_d   = code_byte_i;
          end_d   = stream_end_i;
          left_d  = (rem_q > CAP_C) ? CAP_C : rem_q;
          phase_d = rle_pkg::PH_HEADER;
          rem_d   = '0;
          if (rem_q == '0 && stream_end_i) begin
            ovalid_d = 1'b1;
            oword_d  = '0;
            ocnt_d   = '0;
            olast_d  = 1'b1;
            odone_d  = 1'b1;
            otrunc_d = 1'b0;
          end
        end
        rle_pkg::PH_LITERAL: begin
          // Literal byte passes straight through
          ovalid_d = 1'b1;
          oword_d  = rle_pkg::WORD_W'(code_byte_i);
          ocnt_d   = rle_pkg::BCNT_W'(1);
          olast_d  = 1'b1;
          odone_d  = stream_end_i;
          otrunc_d = stream_end_i && (rem_dec != '0);
          rem_d    = rem_dec;
          phase_d  = (rem_dec == '0) ? rle_pkg::PH_HEADER : rle_pkg::PH_LITERAL;
          if (stream_end_i) begin
            phase_d = rle_pkg::PH_HEADER;
            rem_d   = '0;
          end
        end
        default: begin
          // Header byte (the unused phase code lands here as well)
          rem_d   = hdr_cnt;
          phase_d = hdr_phase;
          if (stream_end_i) begin
            ovalid_d = 1'b1;
            oword_d  = '0;
            ocnt_d   = '0;
            olast_d  = 1'b1;
            odone_d  = 1'b1;
            otrunc_d = (hdr_phase != rle_pkg::PH_HEADER);
            phase_d  = rle_pkg::PH_HEADER;
            rem_d    = '0;
          end
        end
      endcase
    end else if (cmd_i.emit) begin
      // One word of the repeat run
      ovalid_d = 1'b1;
      oword_d  = run_word;
      ocnt_d   = run_n;
      olast_d  = sts_o.last_word;
      odone_d  = end_q && sts_o.last_word;
      otrunc_d = 1'b0;
      left_d   = left_q - rle_pkg::COUNT_W'(run_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rle_pkg::PH_HEADER;
      rem_q    <= '0;
      left_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      left_q   <= left_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    end_q    <= end_d;
    oword_q  <= oword_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
    odone_q  <= odone_d;
    otrunc_q <= otrunc_d;
  end

  assign out_valid_o    = ovalid_q;
  assign out_word_o     = oword_q;
  assign byte_count_o   = ocnt_q;
  assign last_of_item_o = olast_q;
  assign stream_done_o  = odone_q;
  assign truncated_o    = otrunc_q;

endmodule

FILE: rtl/core/rle_byte_stream_decoder.sv
`timescale 1ns / 1ps

// Run-length decoder for a byte-header stream. A header with bit 7 set repeats
// the following value byte (header & 0x7F) times; with bit 7 clear the next
// (header & 0x7F) bytes pass through one result each. Repeat runs leave packed
// into words of WORD_BYTES bytes (1..8), little-endian, the last word short.
// stream_end on an input byte closes the stream: its last result carries
// stream_done, and truncated if a record was left open; the decoder then
// starts fresh. A repeat value byte yields ceil(count / WORD_BYTES) output
// words, capped at 16 words (longer runs are cut), which the run sequencer
// pushes one word per cycle into the output register; no new input byte is
// taken until the run is done. Output backpressure stalls both input and run.
module rle_byte_stream_decoder #(
  parameter int WORD_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rle_in_if.sink     in_i,
  rle_out_if.source  out_o
);

  rle_pkg::rle_cmd_t cmd;
  rle_pkg::rle_sts_t sts;

  rle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rle_dp #(
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .code_byte_i    (in_i.code_byte),
    .stream_end_i   (in_i.stream_end),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_word_o     (out_o.out_word),
    .byte_count_o   (out_o.byte_count),
    .last_of_item_o (out_o.last_of_item),
    .stream_done_o  (out_o.stream_done),
    .truncated_o    (out_o.truncated)
  );

endmodule
